@@ rtl/ffra_pkg.sv @@
package ffra_pkg;

  localparam int NEED_BITS = 22;
  localparam logic [20:0] CAPACITY_RESET = 21'd1048576;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_BASE     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_BADFREE  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_RESET = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RND,
    S_NEED,
    S_SCAN,
    S_PICK,
    S_MR,
    S_ML,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INIT,
    CMD_CLAIM,
    CMD_RELEASE,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      split;
    logic      alloc;
  } cell_cmd_t;

endpackage

@@ rtl/ffra_req_if.sv @@
interface ffra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [20:0] request_size;
  logic [31:0] free_address;

  modport source (output valid, output func, output request_size, output free_address,
                  input ready);
  modport sink (input valid, input func, input request_size, input free_address,
                output ready);
endinterface

@@ rtl/ffra_rsp_if.sv @@
interface ffra_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] granted_address;
  logic [20:0] used_bytes;

  modport source (output valid, output status, output granted_address, output used_bytes,
                  input ready);
  modport sink (input valid, input status, input granted_address, input used_bytes,
                output ready);
endinterface

@@ rtl/ffra_cell.sv @@
module ffra_cell #(
  parameter int IDX         = 0,
  parameter int MAX_REGIONS = 32,
  parameter int OFFSET_BITS = 20,
  parameter int NW          = 22,
  parameter logic [OFFSET_BITS:0] RST_LEN = '0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffra_pkg::cell_cmd_t            cmd,
  input  logic [$clog2(MAX_REGIONS)-1:0] pos,
  input  logic [NW-1:0]                  need,
  input  logic [OFFSET_BITS:0]           init_len,
  input  logic [31:0]                    base,
  input  logic [31:0]                    addr,
  input  logic                           lv,
  input  logic                           lf,
  input  logic [OFFSET_BITS-1:0]         ls,
  input  logic [OFFSET_BITS:0]           ll,
  input  logic                           rv,
  input  logic                           rf,
  input  logic [OFFSET_BITS-1:0]         rs,
  input  logic [OFFSET_BITS:0]           rl,
  output logic                           v,
  output logic                           f,
  output logic [OFFSET_BITS-1:0]         s,
  output logic [OFFSET_BITS:0]           l,
  output logic                           hit,
  output logic                           over
);

  localparam int PW = $clog2(MAX_REGIONS);
  localparam int LW = OFFSET_BITS + 1;
  localparam int CW = (LW > NW) ? LW : NW;
  localparam logic [PW:0] ID = (PW + 1)'(IDX);

  logic [CW-1:0] lenx;
  logic [CW-1:0] needx;
  logic [PW:0]   pe;

  assign lenx  = CW'(l);
  assign needx = CW'(need);
  assign pe    = {1'b0, pos};
  assign over  = lenx > needx;
  assign hit   = cmd.alloc ? (v & f & (lenx >= needx))
                           : (v & ~f & ((base + 32'(s)) == addr));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= (IDX == 0);
      f <= (IDX == 0);
      s <= '0;
      l <= (IDX == 0) ? RST_LEN : '0;
    end else begin
      case (cmd.kind)
        ffra_pkg::CMD_INIT: begin
          v <= (IDX == 0);
          f <= (IDX == 0);
          s <= '0;
          l <= (IDX == 0) ? init_len : '0;
        end
        ffra_pkg::CMD_CLAIM: begin
          if (ID == pe) begin
            l <= LW'(need);
            f <= 1'b0;
          end else if (cmd.split && ID == pe + 1'b1) begin
            v <= 1'b1;
            f <= 1'b1;
            s <= ls + OFFSET_BITS'(need);
            l <= ll - LW'(need);
          end else if (cmd.split && ID > pe + 1'b1) begin
            v <= lv;
            f <= lf;
            s <= ls;
            l <= ll;
          end
        end
        ffra_pkg::CMD_RELEASE: begin
          if (ID == pe) begin
            f <= 1'b1;
          end
        end
        ffra_pkg::CMD_MERGE: begin
          if (ID == pe) begin
            l <= l + rl;
          end else if (ID > pe) begin
            v <= rv;
            f <= rf;
            s <= rs;
            l <= rl;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/first_fit_region_allocator.sv @@
// channel | dir | payload                                   | accepted when
// req     | in  | func, request_size, free_address          | req.valid && req.ready
// rsp     | out | status, granted_address, used_bytes       | rsp.valid && rsp.ready
// apb     | in  | capacity at 0x0, base at 0x4 (pready = 1) | psel && penable && pwrite
//
// One item at a time, from acceptance until idle again: allocate steps through
// rounding multiply, second multiply, scan of the cell chain, claim and result; a
// free that hits through scan, release, merge right, merge left and result; a free
// of an unknown address through scan, pick and result; a zero-size allocate, reset
// and other codes go straight to the result. The steps follow from the two rounding
// multiplies and the one-step-per-cycle shift moves of the region cells.
// Reset gives one free region over the whole buffer in the same cycle; no clearing
// pass. A stalled result holds the block in its result state; req.ready is high
// only when idle and no capacity write is under way.
module first_fit_region_allocator #(
  parameter int MAX_REGIONS   = 32,
  parameter int OFFSET_BITS   = 20,
  parameter int GRANULE_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst,
  ffra_req_if.sink         req,
  ffra_rsp_if.source       rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PW = $clog2(MAX_REGIONS);
  localparam int LW = OFFSET_BITS + 1;
  localparam int NW = ffra_pkg::NEED_BITS;
  localparam int SH = 30;
  localparam longint unsigned LIM = 64'd1 << OFFSET_BITS;
  localparam logic [LW-1:0] RST_LEN = LW'((LIM < 64'd1048576) ? LIM : 64'd1048576);
  localparam logic [30:0] RECIP = 31'(((64'd1 << SH) + GRANULE_BYTES - 1) / GRANULE_BYTES);
  localparam logic [8:0]  GV    = 9'(GRANULE_BYTES);
  localparam logic [NW-1:0] GM1 = NW'(GRANULE_BYTES - 1);

  logic [20:0]          capacity;
  logic [31:0]          base;
  ffra_pkg::state_t     state, state_next;
  logic [1:0]           func_q;
  logic [20:0]          size_q;
  logic [31:0]          addr_q;
  logic [NW+30:0]       prod;
  logic [NW-1:0]        need;
  logic [MAX_REGIONS-1:0] hit_v, over_v;
  logic [PW-1:0]        pos;
  ffra_pkg::status_t    status_q;
  logic [31:0]          grant_q;

  ffra_pkg::cell_cmd_t  cmd;
  logic [PW-1:0]        cmd_pos;

  logic                 ev [MAX_REGIONS+2];
  logic                 ef [MAX_REGIONS+2];
  logic [OFFSET_BITS-1:0] es [MAX_REGIONS+2];
  logic [LW-1:0]        el [MAX_REGIONS+2];
  logic [MAX_REGIONS-1:0] cv, cf, hit, over;

  logic [32:0]          cap33;
  logic [LW-1:0]        init_len;
  logic                 cfg_wr;
  logic [MAX_REGIONS-1:0] first, posoh, last;
  logic [PW-1:0]        fpos;
  logic                 split;
  logic [OFFSET_BITS-1:0] pstart, lstart;
  logic [20:0]          used;
  logic                 right_free, left_free;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == ffra_pkg::REG_BASE) ? base : 32'(capacity);
  assign cap33  = (cfg_wr && paddr[2] == ffra_pkg::REG_CAPACITY) ? 33'(pwdata[20:0])
                                                                 : 33'(capacity);
  assign init_len = LW'((cap33 < 33'(LIM)) ? cap33 : 33'(LIM));

  assign ev[0] = 1'b0;
  assign ef[0] = 1'b0;
  assign es[0] = '0;
  assign el[0] = '0;
  assign ev[MAX_REGIONS+1] = 1'b0;
  assign ef[MAX_REGIONS+1] = 1'b0;
  assign es[MAX_REGIONS+1] = '0;
  assign el[MAX_REGIONS+1] = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    ffra_cell #(
      .IDX(i), .MAX_REGIONS(MAX_REGIONS), .OFFSET_BITS(OFFSET_BITS), .NW(NW),
      .RST_LEN(RST_LEN)
    ) u_cell (
      .clk, .rst, .cmd, .pos(cmd_pos), .need, .init_len, .base, .addr(addr_q),
      .lv(ev[i]), .lf(ef[i]), .ls(es[i]), .ll(el[i]),
      .rv(ev[i+2]), .rf(ef[i+2]), .rs(es[i+2]), .rl(el[i+2]),
      .v(ev[i+1]), .f(ef[i+1]), .s(es[i+1]), .l(el[i+1]),
      .hit(hit[i]), .over(over[i])
    );
    assign cv[i] = ev[i+1];
    assign cf[i] = ef[i+1];
  end

  always_comb begin
    first  = hit_v & (~hit_v + 1'b1);
    posoh  = MAX_REGIONS'(1) << pos;
    last   = cv & ~(cv >> 1);
    fpos   = '0;
    pstart = '0;
    lstart = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (first[i]) begin
        fpos   = fpos | PW'(i);
        pstart = pstart | es[i+1];
      end
      if (last[i]) begin
        lstart = lstart | es[i+1];
      end
    end
    split      = |(first & over_v);
    right_free = |((posoh << 1) & cv & cf);
    left_free  = |((posoh >> 1) & cf);
    used       = cv[1] ? 21'(lstart) : 21'd0;
  end

  always_comb begin
    state_next = state;
    cmd        = '{kind: ffra_pkg::CMD_HOLD, split: 1'b0,
                   alloc: (func_q == ffra_pkg::FN_ALLOC)};
    cmd_pos    = pos;
    req.ready  = (state == ffra_pkg::S_IDLE) &&
                 !(cfg_wr && paddr[2] == ffra_pkg::REG_CAPACITY);
    case (state)
      ffra_pkg::S_IDLE: begin
        if (cfg_wr && paddr[2] == ffra_pkg::REG_CAPACITY) begin
          cmd.kind = ffra_pkg::CMD_INIT;
        end else if (req.valid) begin
          case (ffra_pkg::func_t'(req.func))
            ffra_pkg::FN_ALLOC: begin
              state_next = (req.request_size == '0) ? ffra_pkg::S_DONE : ffra_pkg::S_RND;
            end
            ffra_pkg::FN_FREE: begin
              state_next = ffra_pkg::S_SCAN;
            end
            ffra_pkg::FN_RESET: begin
              cmd.kind   = ffra_pkg::CMD_INIT;
              state_next = ffra_pkg::S_DONE;
            end
            default: begin
              state_next = ffra_pkg::S_DONE;
            end
          endcase
        end
      end
      ffra_pkg::S_RND: state_next = ffra_pkg::S_NEED;
      ffra_pkg::S_NEED: state_next = ffra_pkg::S_SCAN;
      ffra_pkg::S_SCAN: state_next = ffra_pkg::S_PICK;
      ffra_pkg::S_PICK: begin
        state_next = ffra_pkg::S_DONE;
        cmd_pos    = fpos;
        if (|hit_v) begin
          if (func_q == ffra_pkg::FN_ALLOC) begin
            if (!(split && cv[MAX_REGIONS-1])) begin
              cmd.kind  = ffra_pkg::CMD_CLAIM;
              cmd.split = split;
            end
          end else begin
            cmd.kind   = ffra_pkg::CMD_RELEASE;
            state_next = ffra_pkg::S_MR;
          end
        end
      end
      ffra_pkg::S_MR: begin
        state_next = ffra_pkg::S_ML;
        if (right_free) begin
          cmd.kind = ffra_pkg::CMD_MERGE;
        end
      end
      ffra_pkg::S_ML: begin
        state_next = ffra_pkg::S_DONE;
        cmd_pos    = pos - PW'(1);
        if (pos != '0 && left_free) begin
          cmd.kind = ffra_pkg::CMD_MERGE;
        end
      end
      ffra_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ffra_pkg::S_IDLE;
        end
      end
      default: state_next = ffra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= ffra_pkg::CAPACITY_RESET;
      base      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == ffra_pkg::REG_CAPACITY) begin
        capacity <= pwdata[20:0];
      end
      if (cfg_wr && paddr[2] == ffra_pkg::REG_BASE) begin
        base <= pwdata;
      end
      if (state == ffra_pkg::S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ffra_pkg::S_IDLE: begin
        if (req.valid) begin
          func_q   <= req.func;
          size_q   <= req.request_size;
          addr_q   <= req.free_address;
          grant_q  <= '0;
          status_q <= (req.func == ffra_pkg::FN_ALLOC && req.request_size == '0)
                      ? ffra_pkg::ST_ZERO : ffra_pkg::ST_OK;
        end
      end
      ffra_pkg::S_RND: begin
        prod <= (NW + 31)'((NW'(size_q) + GM1) * RECIP);
      end
      ffra_pkg::S_NEED: begin
        need <= NW'(prod[NW+30:SH] * GV);
      end
      ffra_pkg::S_SCAN: begin
        hit_v  <= hit;
        over_v <= over;
      end
      ffra_pkg::S_PICK: begin
        pos <= fpos;
        if (!(|hit_v)) begin
          status_q <= (func_q == ffra_pkg::FN_ALLOC) ? ffra_pkg::ST_NOSPACE
                                                     : ffra_pkg::ST_BADFREE;
        end else if (func_q == ffra_pkg::FN_ALLOC) begin
          if (split && cv[MAX_REGIONS-1]) begin
            status_q <= ffra_pkg::ST_FULL;
          end else begin
            grant_q <= base + 32'(pstart);
          end
        end
      end
      ffra_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.status          <= status_q;
          rsp.granted_address <= grant_q;
          rsp.used_bytes      <= used;
        end
      end
      default: begin
      end
    endcase
  end

  a_first_cell_valid: assert property (@(posedge clk) disable iff (rst) cv[0])
    else $error("first region missing");
  a_regions_packed: assert property (@(posedge clk) disable iff (rst)
    ((cv >> 1) & ~cv) == '0)
    else $error("hole in region table");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != ffra_pkg::S_IDLE)
    else $error("item accepted without work");
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ffra_pkg::ST_OK |-> rsp.granted_address == '0)
    else $error("address granted on failure");

endmodule

@@ tb/first_fit_region_allocator_test.sv @@
module first_fit_region_allocator_test;

  localparam int MAXR = 32;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  func;
    logic [20:0] size;
    logic [31:0] addr;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted;
    logic [20:0] used;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ffra_req_if req();
  ffra_rsp_if rsp();

  first_fit_region_allocator dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow
  logic [20:0] cap_m;
  logic [31:0] base_m;
  logic [20:0] rs [MAXR];
  logic [20:0] rl [MAXR];
  logic        rf [MAXR];
  int          cnt_m;
  logic [20:0] used_m;

  op_t  pending[$];
  res_t expected[$];
  int   errors = 0;
  int   accepted_in = 0, accepted_out = 0;
  int   n_ok = 0, n_err = 0;
  bit   hold_rsp = 0;
  bit   stall_long = 0;
  bit   req_taken = 0;
  int   idle_cycles = 0;

  function automatic void table_init();
    for (int k = 0; k < MAXR; k++) begin
      rs[k] = '0; rl[k] = '0; rf[k] = 1'b0;
    end
    rl[0] = (cap_m > 21'd1048576) ? 21'd1048576 : cap_m;
    rf[0] = 1'b1;
    cnt_m = 1;
    used_m = '0;
  endfunction

  function automatic void refresh_used();
    used_m = (cnt_m >= 2) ? rs[cnt_m-1] : '0;
  endfunction

  function automatic void remove_entry(int i);
    for (int k = i; k + 1 < cnt_m; k++) begin
      rs[k] = rs[k+1]; rl[k] = rl[k+1]; rf[k] = rf[k+1];
    end
    cnt_m--;
    rs[cnt_m] = '0; rl[cnt_m] = '0; rf[cnt_m] = 1'b0;
  endfunction

  function automatic res_t allocate_step(op_t op);
    res_t r;
    logic [21:0] need;
    r = '0;
    r.status = ffra_pkg::ST_OK;
    if (ffra_pkg::func_t'(op.func) == ffra_pkg::FN_ALLOC) begin
      if (op.size == 0) r.status = ffra_pkg::ST_ZERO;
      else begin
        need = ({1'b0, op.size} + 22'd15) & ~22'd15;
        r.status = ffra_pkg::ST_NOSPACE;
        for (int i = 0; i < cnt_m; i++) begin
          if (!rf[i] || {1'b0, rl[i]} < need) continue;
          if ({1'b0, rl[i]} > need) begin
            if (cnt_m >= MAXR) begin
              r.status = ffra_pkg::ST_FULL;
              break;
            end
            for (int k = cnt_m; k > i + 1; k--) begin
              rs[k] = rs[k-1]; rl[k] = rl[k-1]; rf[k] = rf[k-1];
            end
            cnt_m++;
            rs[i+1] = rs[i] + need[20:0];
            rl[i+1] = rl[i] - need[20:0];
            rf[i+1] = 1'b1;
          end
          rl[i] = need[20:0];
          rf[i] = 1'b0;
          refresh_used();
          r.granted = base_m + {11'd0, rs[i]};
          r.status = ffra_pkg::ST_OK;
          break;
        end
      end
    end else if (ffra_pkg::func_t'(op.func) == ffra_pkg::FN_FREE) begin
      r.status = ffra_pkg::ST_BADFREE;
      for (int i = 0; i < cnt_m; i++) begin
        if (rf[i] || base_m + {11'd0, rs[i]} != op.addr) continue;
        rf[i] = 1'b1;
        if (i + 1 < cnt_m && rf[i+1]) begin
          rl[i] = rl[i] + rl[i+1];
          remove_entry(i + 1);
        end
        if (i > 0 && rf[i-1]) begin
          rl[i-1] = rl[i-1] + rl[i];
          remove_entry(i);
        end
        refresh_used();
        r.status = ffra_pkg::ST_OK;
        break;
      end
    end else if (ffra_pkg::func_t'(op.func) == ffra_pkg::FN_RESET) begin
      table_init();
    end
    r.used = used_m;
    return r;
  endfunction

  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
  end

  // request driver
  int gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_taken) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      req.valid <= 1'b0;
    end else if (pending.size() > 0) begin
      op_t op;
      op = pending.pop_front();
      req.valid <= 1'b1;
      req.func <= op.func;
      req.request_size <= op.size;
      req.free_address <= op.addr;
      gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
             ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
    end else begin
      req.valid <= 1'b0;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.request_size = '0;
    req.free_address = '0;
    rsp.ready = 1'b0;
  end

  // response stall
  int rgap = 0;
  int long_count = 0;
  always @(negedge clk) begin
    if (rst || hold_rsp) begin
      rsp.ready <= 1'b0;
    end else if (stall_long) begin
      rsp.ready <= 1'b0;
      if (long_count == 300) begin
        stall_long <= 1'b0;
        long_count <= 0;
      end else begin
        long_count <= long_count + 1;
      end
    end else if (rgap > 0) begin
      rgap <= rgap - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      rgap <= ($urandom_range(0, 12) == 0) ? $urandom_range(5, 30) :
              ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (req.valid && req.ready) begin
        op_t op;
        op = '{req.func, req.request_size, req.free_address};
        expected.push_back(allocate_step(op));
        accepted_in <= accepted_in + 1;
      end
      if (rsp.valid && rsp.ready) begin
        res_t e;
        accepted_out <= accepted_out + 1;
        if (expected.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr=%h used=%h", $realtime,
                   rsp.status, rsp.granted_address, rsp.used_bytes);
          errors = errors + 1;
        end else begin
          e = expected.pop_front();
          if (e.status == ffra_pkg::ST_OK) n_ok <= n_ok + 1;
          else n_err <= n_err + 1;
          if (rsp.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, rsp.status);
            errors = errors + 1;
          end
          if (rsp.granted_address !== e.granted) begin
            $display("%0t: address expected %h actual %h", $realtime, e.granted,
                     rsp.granted_address);
            errors = errors + 1;
          end
          if (rsp.used_bytes !== e.used) begin
            $display("%0t: used expected %h actual %h", $realtime, e.used, rsp.used_bytes);
            errors = errors + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > LIMIT) begin
      $display("timeout");
      $display("first_fit_region_allocator_test NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ffra_pkg::REG_CAPACITY) begin
      cap_m = val[20:0];
      table_init();
    end else begin
      base_m = val;
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected.size() > 0 || req.valid) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic op_t mk(ffra_pkg::func_t f, logic [20:0] s, logic [31:0] a);
    op_t o;
    o.func = f; o.size = s; o.addr = a;
    return o;
  endfunction

  logic [31:0] live[$];

  function automatic op_t rand_op(int capsz);
    int sel;
    logic [20:0] s;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      s = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(1, capsz + 64)) :
          21'($urandom_range(1, capsz / 8 + 1));
      return mk(ffra_pkg::FN_ALLOC, s, $urandom);
    end else if (sel < 85 && live.size() > 0) begin
      int j;
      j = $urandom_range(0, live.size() - 1);
      return mk(ffra_pkg::FN_FREE, 21'($urandom), live[j]);
    end else if (sel < 88) begin
      return mk(ffra_pkg::FN_FREE, 21'($urandom), $urandom);
    end else if (sel < 90) begin
      return mk(ffra_pkg::FN_RESET, 21'($urandom), $urandom);
    end else if (sel < 91) begin
      return mk(ffra_pkg::FN_NONE, 21'($urandom), $urandom);
    end else if (sel < 93) begin
      return mk(ffra_pkg::FN_ALLOC, 21'd0, $urandom);
    end else begin
      return mk(ffra_pkg::FN_ALLOC, 21'($urandom_range(1, 64)), $urandom);
    end
  endfunction

  initial begin
    int caps[5];
    logic [31:0] bases[5];
    base_m = '0;
    cap_m = ffra_pkg::CAPACITY_RESET;
    table_init();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(ffra_pkg::REG_BASE, 32'hFFFF_FFF0);
    write_reg(ffra_pkg::REG_CAPACITY, 32'h001F_FFFF);
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd0, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd1, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd17, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'h1FFFFF, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'h1FFFFF, 32'hFFFF_FFF0));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'd0, 32'h0000_0000));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'd0, 32'hFFFF_FFF0));
    pending.push_back(mk(ffra_pkg::FN_NONE, 21'h1FFFFF, 32'hFFFF_FFFF));
    for (int k = 0; k < 33; k++) pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd16, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'd0, 32'h0000_0010));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd32, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd8, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_RESET, 21'd0, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_ALLOC, 21'd1048576, 32'd0));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'd0, 32'h0));
    pending.push_back(mk(ffra_pkg::FN_FREE, 21'd0, 32'hFFFF_FFF0));
    drain();

    caps[0] = 0; caps[1] = 4096; caps[2] = 1048576; caps[3] = 100; caps[4] = 1024;
    bases[0] = 32'h0; bases[1] = 32'h8000_0000; bases[2] = 32'hFFFF_F000;
    bases[3] = 32'hFFFF_FFFF; bases[4] = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      int capsz;
      logic [31:0] b;
      capsz = caps[ph];
      b = bases[ph];
      write_reg(ffra_pkg::REG_CAPACITY, 32'(capsz));
      write_reg(ffra_pkg::REG_BASE, b);
      live.delete();
      for (int k = 0; k < 64; k++) live.push_back(b + 32'(16 * $urandom_range(0, capsz / 16)));
      if (ph == 2) begin
        stall_long = 1'b1;
      end
      for (int n = 0; n < 320; n++) pending.push_back(rand_op(capsz == 0 ? 64 : capsz));
      if (ph == 3) begin
        while (pending.size() > 0 || req.valid) @(posedge clk);
        while (expected.size() > 0) @(posedge clk);
        for (int n = 0; n < 20; n++) pending.push_back(rand_op(capsz));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("items in %0d, results %0d (ok %0d, flagged %0d), 5 capacity/base settings",
             accepted_in, accepted_out, n_ok, n_err);
    if (errors == 0 && expected.size() == 0) begin
      $display("first_fit_region_allocator_test OK");
    end else begin
      $display("first_fit_region_allocator_test NOT OK");
    end
    $finish;
  end
endmodule
